[rtl/core/fsrm_pkg.sv]
`timescale 1ns / 1ps

package fsrm_pkg;

  // fixed field widths
  localparam int OP_W       = 3;
  localparam int STATUS_W   = 3;
  localparam int FSIZE_W    = 25;
  localparam int STAMP_W    = 64;
  localparam int SLOT_IDX_W = 8;
  localparam int OFFSET_W   = 32;
  localparam int COUNT_W    = 9;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int SIZE_BITS_DEF = 25;

  // register value limits
  localparam int                 MIN_SLOTS     = 2;
  localparam logic [FSIZE_W-1:0] SLOT_SIZE_MIN = 25'd1;
  localparam logic [FSIZE_W-1:0] SLOT_SIZE_MAX = 25'h100_0000;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN_WRITE  = 3'd0,
    OP_COMMIT_WRITE = 3'd1,
    OP_POP          = 3'd2,
    OP_RELEASE_READ = 3'd3,
    OP_CLOSE        = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_SEQ_ERR   = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT = 4'd0,
    REG_SLOT_SIZE  = 4'd1
  } cfg_reg_e;

endpackage

[rtl/core/frame_slot_ring_manager.sv]
`timescale 1ns / 1ps

// Slot bookkeeping for a frame ring shared by one producer and one consumer.
// Operations enter on the command channel: an operation is taken at a clock
// edge with start high and busy low; busy stays low, so one operation may be
// issued every cycle. Each operation gives exactly one result: res_valid_o is
// high for one cycle with status, slot, byte offset, popped metadata, queued
// count and the closed flag. Results cannot be held off, so nothing ever
// stalls inside the block. An operation passes the operation register, then
// the result register, and one operation is taken per cycle; the metadata
// memory is read at the next tail slot when an operation is accepted, with
// write data forwarded on a hit. The user must write slot_count and
// slot_size on the cfg channel (index 0 and 1) only while no operation is
// in flight; the block does not enforce it. cfg_ready_o is always high.
// Reset clears head, tail, queued count, open-phase flags and the closed flag,
// sets slot_count to 2 and slot_size to 1; the metadata memory is not
// cleared and needs no sweep, as no slot is read before it is committed.
module frame_slot_ring_manager
  import fsrm_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [OP_W-1:0]              operation_i,
  input  logic [FSIZE_W-1:0]           frame_size_i,
  input  logic signed [STAMP_W-1:0]    timestamp_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  output logic                         res_valid_o,
  output logic [STATUS_W-1:0]          status_o,
  output logic [SLOT_IDX_W-1:0]        slot_index_o,
  output logic [OFFSET_W-1:0]          byte_offset_o,
  output logic [FSIZE_W-1:0]           out_size_o,
  output logic signed [STAMP_W-1:0]    out_timestamp_o,
  output logic [COUNT_W-1:0]           queued_count_o,
  output logic                         is_closed_o
);

  localparam int PW    = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int EW    = (PW + 1 > COUNT_W) ? PW + 1 : COUNT_W;
  localparam int IW    = (PW + 1 > COUNT_W + 1) ? PW + 1 : COUNT_W + 1;
  localparam int PRODW = PW + FSIZE_W;

  // configuration
  logic [COUNT_W-1:0] slot_count_q;
  logic [FSIZE_W-1:0] slot_size_q;

  // ring state
  logic [PW-1:0]      head_q, head_d;
  logic [PW-1:0]      tail_q, tail_d;
  logic [COUNT_W-1:0] queued_q, queued_d;
  logic               wp_q, wp_d;
  logic               rp_q, rp_d;
  logic               closed_q, closed_d;

  // operation register
  logic                      vld_q;
  logic [OP_W-1:0]           op_q;
  logic [FSIZE_W-1:0]        fsize_q;
  logic signed [STAMP_W-1:0] stamp_q;

  // metadata memory
  logic [SIZE_BITS-1:0]      size_mem [MAX_SLOTS];
  logic signed [STAMP_W-1:0] stamp_mem [MAX_SLOTS];
  logic [SIZE_BITS-1:0]      rd_size_q;
  logic signed [STAMP_W-1:0] rd_stamp_q;
  logic                      mem_we;

  // result register
  logic                      res_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic [SLOT_IDX_W-1:0]     slot_idx_q;
  logic [OFFSET_W-1:0]       offset_q;
  logic [FSIZE_W-1:0]        osize_q;
  logic signed [STAMP_W-1:0] ostamp_q;
  logic [COUNT_W-1:0]        oqueued_q;
  logic                      oclosed_q;

  logic [EW-1:0]      cnt_ext;
  logic [PW:0]        eff_cnt;
  logic [FSIZE_W-1:0] eff_bytes;
  logic [IW-1:0]      in_use;
  logic [PW:0]        head_inc, tail_inc;
  logic [PW-1:0]      head_adv, tail_adv;
  logic [PW-1:0]      slot_sel;
  logic [PRODW-1:0]   prod;
  logic               grant;
  status_e            status;
  logic               accept;

  assign accept      = start && !busy;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // register values clamped into their meaningful ranges
  always_comb begin
    cnt_ext = EW'(slot_count_q);
    if (cnt_ext < EW'(MIN_SLOTS)) begin
      eff_cnt = (PW+1)'(MIN_SLOTS);
    end else if (cnt_ext > EW'(MAX_SLOTS)) begin
      eff_cnt = (PW+1)'(MAX_SLOTS);
    end else begin
      eff_cnt = (PW+1)'(cnt_ext);
    end
    if (slot_size_q < SLOT_SIZE_MIN) begin
      eff_bytes = SLOT_SIZE_MIN;
    end else if (slot_size_q > SLOT_SIZE_MAX) begin
      eff_bytes = SLOT_SIZE_MAX;
    end else begin
      eff_bytes = slot_size_q;
    end
  end

  // pointers wrap to zero at or beyond the slot count, also after a resize
  assign head_inc = {1'b0, head_q} + (PW+1)'(1);
  assign tail_inc = {1'b0, tail_q} + (PW+1)'(1);
  assign head_adv = (head_inc >= eff_cnt) ? '0 : head_inc[PW-1:0];
  assign tail_adv = (tail_inc >= eff_cnt) ? '0 : tail_inc[PW-1:0];
  assign in_use   = IW'(queued_q) + IW'(rp_q);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    queued_d = queued_q;
    wp_d     = wp_q;
    rp_d     = rp_q;
    closed_d = closed_q;
    status   = ST_OK;
    grant    = 1'b0;
    mem_we   = 1'b0;
    if (vld_q) begin
      unique case (op_q)
        OP_BEGIN_WRITE: begin
          if (closed_q || wp_q || (in_use >= IW'(eff_cnt))) begin
            status = ST_REFUSED;
          end else begin
            wp_d  = 1'b1;
            grant = 1'b1;
          end
        end
        OP_COMMIT_WRITE: begin
          if (!wp_q) begin
            status = ST_SEQ_ERR;
          end else if (fsize_q > eff_bytes) begin
            status = ST_TOO_LARGE;
          end else begin
            mem_we   = 1'b1;
            head_d   = head_adv;
            queued_d = (queued_q != '1) ? queued_q + COUNT_W'(1) : queued_q;
            wp_d     = 1'b0;
            grant    = 1'b1;
          end
        end
        OP_POP: begin
          if (rp_q) begin
            status = ST_SEQ_ERR;
          end else if (queued_q == '0) begin
            status = ST_EMPTY;
          end else begin
            rp_d  = 1'b1;
            grant = 1'b1;
          end
        end
        OP_RELEASE_READ: begin
          if (!rp_q) begin
            status = ST_SEQ_ERR;
          end else begin
            tail_d   = tail_adv;
            queued_d = (queued_q != '0) ? queued_q - COUNT_W'(1) : queued_q;
            rp_d     = 1'b0;
            grant    = 1'b1;
          end
        end
        OP_CLOSE: closed_d = 1'b1;
        default:  status = ST_SEQ_ERR;
      endcase
    end
  end

  // writers use the head slot, readers the tail slot
  assign slot_sel = ((op_q == OP_BEGIN_WRITE) || (op_q == OP_COMMIT_WRITE)) ? head_q : tail_q;
  assign prod     = PRODW'(slot_sel) * PRODW'(eff_bytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= COUNT_W'(MIN_SLOTS);
      slot_size_q  <= SLOT_SIZE_MIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_SLOT_COUNT: slot_count_q <= cfg_data_i[COUNT_W-1:0];
        REG_SLOT_SIZE:  slot_size_q  <= cfg_data_i[FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      queued_q    <= '0;
      wp_q        <= 1'b0;
      rp_q        <= 1'b0;
      closed_q    <= 1'b0;
      vld_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      queued_q    <= queued_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      closed_q    <= closed_d;
      vld_q       <= accept;
      res_valid_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= operation_i;
      fsize_q <= frame_size_i;
      stamp_q <= timestamp_i;
    end
  end

  // read when an operation is accepted, at the tail this operation will see
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      size_mem[head_q]  <= SIZE_BITS'(fsize_q);
      stamp_mem[head_q] <= stamp_q;
    end
    if (accept) begin
      if (mem_we && (head_q == tail_d)) begin
        rd_size_q  <= SIZE_BITS'(fsize_q);
        rd_stamp_q <= stamp_q;
      end else begin
        rd_size_q  <= size_mem[tail_d];
        rd_stamp_q <= stamp_mem[tail_d];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      status_q   <= status;
      slot_idx_q <= grant ? SLOT_IDX_W'(slot_sel) : '0;
      offset_q   <= grant ? OFFSET_W'(prod) : '0;
      if (grant && (op_q == OP_POP)) begin
        osize_q  <= FSIZE_W'(rd_size_q);
        ostamp_q <= rd_stamp_q;
      end else begin
        osize_q  <= '0;
        ostamp_q <= '0;
      end
      oqueued_q <= queued_d;
      oclosed_q <= closed_d;
    end
  end

  assign res_valid_o     = res_valid_q;
  assign status_o        = status_q;
  assign slot_index_o    = slot_idx_q;
  assign byte_offset_o   = offset_q;
  assign out_size_o      = osize_q;
  assign out_timestamp_o = ostamp_q;
  assign queued_count_o  = oqueued_q;
  assign is_closed_o     = oclosed_q;

`ifndef NO_ASSERTIONS
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 res_valid_o)
    else $error("accepted operation produced no result");

  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (status_o != ST_OK)) |->
      (slot_index_o == '0) && (byte_offset_o == '0) &&
      (out_size_o == '0) && (out_timestamp_o == '0))
    else $error("failed operation reports slot data");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(closed_q) |-> closed_q)
    else $error("closed flag cleared");

  a_queued_moves_on_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queued_q != $past(queued_q)) |-> $past(vld_q))
    else $error("queued count changed without an operation");
`endif

endmodule
